>>> rtl/mssw_pkg.sv
package mssw_pkg;

	localparam int MAX_SIDE    = 32;
	localparam int SAMPLE_BITS = 16;

	// fixed field widths
	localparam int IN_BITS        = 16;
	localparam int SUM_BITS       = 26;
	localparam int POS_BITS       = 5;
	localparam int CFG_BITS       = 6;
	localparam int CFG_INDEX_BITS = 2;

	localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
	localparam int IDX_BITS  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CNT_BITS  = $clog2(MAX_SIDE + 1);
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_BITS  = SAMPLE_BITS + ADDR_BITS + 1;
	localparam int WIDE_BITS = (ACC_BITS > SUM_BITS) ? ACC_BITS : SUM_BITS;
	localparam int SIDE_CMP_BITS = (CFG_BITS > CNT_BITS) ? CFG_BITS : CNT_BITS;

	localparam logic signed [WIDE_BITS-1:0] SUM_MAX_W = (WIDE_BITS'(1) << (SUM_BITS - 1)) - 1;
	localparam logic signed [WIDE_BITS-1:0] SUM_MIN_W = -SUM_MAX_W - 1;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COL_COUNT   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIDE = 2'd2;

	localparam logic [CFG_BITS-1:0] ROW_COUNT_RST   = 6'd32;
	localparam logic [CFG_BITS-1:0] COL_COUNT_RST   = 6'd32;
	localparam logic [CFG_BITS-1:0] WINDOW_SIDE_RST = 6'd1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] rows;
		logic [CNT_BITS-1:0] cols;
		logic [CNT_BITS-1:0] side;
	} dims_t;

	// travels alongside each memory read
	typedef struct packed {
		logic                valid;
		logic                first;
		logic                last;
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
	} tag_t;

	function automatic logic [CNT_BITS-1:0] clamp_side(input logic [CFG_BITS-1:0] v);
		logic [CNT_BITS-1:0] r;
		if (v == '0) begin
			r = CNT_BITS'(1);
		end else if (int'(v) > MAX_SIDE) begin
			r = CNT_BITS'(MAX_SIDE);
		end else begin
			r = CNT_BITS'(v);
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] to_store(input logic [IN_BITS-1:0] s);
		logic [31:0] raw;
		raw = {16'b0, s};
		return raw[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [IDX_BITS-1:0] row,
		input logic [IDX_BITS-1:0] col);
		return ADDR_BITS'(int'(row) * MAX_SIDE + int'(col));
	endfunction

endpackage

>>> rtl/mssw_if.sv
interface mssw_in_if;
	import mssw_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [IN_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mssw_out_if;
	import mssw_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SUM_BITS-1:0] best_sum;
	logic [POS_BITS-1:0]        top_row;
	logic [POS_BITS-1:0]        left_col;
	logic                       bad_window;

	modport source (output valid, output best_sum, output top_row, output left_col,
		output bad_window, input ready);
	modport sink   (input valid, input best_sum, input top_row, input left_col,
		input bad_window, output ready);
endinterface

>>> rtl/mssw_ram.sv
module mssw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mssw_addr_gen.sv
module mssw_addr_gen (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load_en,
	input  logic                       scan_start,
	input  mssw_pkg::dims_t            dims,
	output logic                       wr_en,
	output logic [mssw_pkg::ADDR_BITS-1:0] wr_addr,
	output logic [mssw_pkg::ADDR_BITS-1:0] rd_addr,
	output mssw_pkg::tag_t             tag,
	output logic                       load_last,
	output logic                       busy
);
	import mssw_pkg::*;

	logic [IDX_BITS-1:0] ld_row_q, ld_col_q;
	logic [IDX_BITS-1:0] win_row_q, win_col_q, el_row_q, el_col_q;
	logic                active_q;
	tag_t                tag_now, tag_s1;
	logic                ld_col_end, ld_row_end;
	logic                el_col_end, el_row_end, win_col_end, win_row_end;
	logic [IDX_BITS-1:0] rd_row, rd_col;

	assign ld_col_end = CNT_BITS'(ld_col_q) == dims.cols - CNT_BITS'(1);
	assign ld_row_end = CNT_BITS'(ld_row_q) == dims.rows - CNT_BITS'(1);
	assign load_last  = ld_col_end && ld_row_end;

	assign wr_en   = load_en;
	assign wr_addr = elem_addr(ld_row_q, ld_col_q);

	// raster walk over the matrix as items arrive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (load_en) begin
			if (load_last) begin
				ld_row_q <= '0;
				ld_col_q <= '0;
			end else if (ld_col_end) begin
				ld_col_q <= '0;
				ld_row_q <= ld_row_q + 1'b1;
			end else begin
				ld_col_q <= ld_col_q + 1'b1;
			end
		end
	end

	assign el_col_end  = CNT_BITS'(el_col_q) == dims.side - CNT_BITS'(1);
	assign el_row_end  = CNT_BITS'(el_row_q) == dims.side - CNT_BITS'(1);
	assign win_col_end = CNT_BITS'(win_col_q) == dims.cols - dims.side;
	assign win_row_end = CNT_BITS'(win_row_q) == dims.rows - dims.side;

	// window position never runs past the last row or column
	assign rd_row  = win_row_q + el_row_q;
	assign rd_col  = win_col_q + el_col_q;
	assign rd_addr = elem_addr(rd_row, rd_col);

	// one element read per cycle: element column, element row, window column, window row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			win_row_q <= '0;
			win_col_q <= '0;
			el_row_q  <= '0;
			el_col_q  <= '0;
		end else if (scan_start) begin
			active_q  <= 1'b1;
			win_row_q <= '0;
			win_col_q <= '0;
			el_row_q  <= '0;
			el_col_q  <= '0;
		end else if (active_q) begin
			if (el_col_end) begin
				el_col_q <= '0;
				if (el_row_end) begin
					el_row_q <= '0;
					if (win_col_end) begin
						win_col_q <= '0;
						if (win_row_end) begin
							active_q <= 1'b0;
						end else begin
							win_row_q <= win_row_q + 1'b1;
						end
					end else begin
						win_col_q <= win_col_q + 1'b1;
					end
				end else begin
					el_row_q <= el_row_q + 1'b1;
				end
			end else begin
				el_col_q <= el_col_q + 1'b1;
			end
		end
	end

	always_comb begin
		tag_now.valid = active_q;
		tag_now.first = (el_row_q == '0) && (el_col_q == '0);
		tag_now.last  = el_col_end && el_row_end;
		tag_now.row   = win_row_q;
		tag_now.col   = win_col_q;
	end

	// lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_now;
		end
	end

	assign tag  = tag_s1;
	assign busy = active_q || tag_s1.valid;

endmodule

>>> rtl/mssw_best.sv
module mssw_best (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  mssw_pkg::tag_t                      tag,
	input  logic [mssw_pkg::SAMPLE_BITS-1:0]    rd_data,
	output logic signed [mssw_pkg::SUM_BITS-1:0] best_sum,
	output logic [mssw_pkg::IDX_BITS-1:0]       best_row,
	output logic [mssw_pkg::IDX_BITS-1:0]       best_col,
	output logic                                busy
);
	import mssw_pkg::*;

	logic signed [ACC_BITS-1:0]  acc_q, acc_next, smp;
	logic signed [WIDE_BITS-1:0] wide;
	logic signed [SUM_BITS-1:0]  sat;
	logic signed [SUM_BITS-1:0]  sum_s2;
	logic [IDX_BITS-1:0]         row_s2, col_s2;
	logic                        valid_s2;
	logic                        have_q;
	logic signed [SUM_BITS-1:0]  best_q;
	logic [IDX_BITS-1:0]         best_row_q, best_col_q;

	assign smp      = ACC_BITS'(signed'(rd_data));
	assign acc_next = (tag.first ? ACC_BITS'(0) : acc_q) + smp;
	assign wide     = WIDE_BITS'(acc_next);

	always_comb begin
		if (wide > SUM_MAX_W) begin
			sat = SUM_BITS'(SUM_MAX_W);
		end else if (wide < SUM_MIN_W) begin
			sat = SUM_BITS'(SUM_MIN_W);
		end else begin
			sat = SUM_BITS'(wide);
		end
	end

	always_ff @(posedge clk) begin
		if (tag.valid) begin
			acc_q <= acc_next;
		end
		if (tag.valid && tag.last) begin
			sum_s2 <= sat;
			row_s2 <= tag.row;
			col_s2 <= tag.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= tag.valid && tag.last;
		end
	end

	// first window seeds the best, later ones must be strictly larger
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (clear) begin
			have_q <= 1'b0;
		end else if (valid_s2 && (!have_q || sum_s2 > best_q)) begin
			have_q     <= 1'b1;
			best_q     <= sum_s2;
			best_row_q <= row_s2;
			best_col_q <= col_s2;
		end
	end

	assign best_sum = best_q;
	assign best_row = best_row_q;
	assign best_col = best_col_q;
	assign busy     = valid_s2;

endmodule

>>> rtl/max_sum_square_window.sv
// Loads a row_count by col_count matrix of signed samples in raster order, one item per
// cycle with no stall, then searches every window_side square window for the largest
// sum (first window in raster order wins a tie) and emits one result. The search reads
// the sample memory once per cycle, one element a cycle, and no item is taken during it;
// a bad window side skips the search and reports directly. Counts of 0 act as 1 and counts
// above 32 act as 32. The next matrix may load while the previous result waits on the output.
// The sample memory is not cleared after reset.
module max_sum_square_window (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mssw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mssw_pkg::CFG_BITS-1:0]       cfg_data,
	mssw_in_if.sink                             in_ch,
	mssw_out_if.source                          out_ch
);
	import mssw_pkg::*;

	logic [CFG_BITS-1:0]        row_q, col_q, side_q;
	dims_t                      dims;
	logic [CNT_BITS-1:0]        small_side;
	logic                       bad;
	state_t                     state_q, state_next;
	logic                       load_en, load_last, scan_start, result_load;
	logic                       gen_busy, best_busy;
	logic                       wr_en;
	logic [ADDR_BITS-1:0]       wr_addr, rd_addr;
	logic [SAMPLE_BITS-1:0]     rd_data;
	tag_t                       tag;
	logic signed [SUM_BITS-1:0] best_sum;
	logic [IDX_BITS-1:0]        best_row, best_col;
	logic                       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= ROW_COUNT_RST;
			col_q  <= COL_COUNT_RST;
			side_q <= WINDOW_SIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_COUNT:   row_q  <= cfg_data;
				REG_COL_COUNT:   col_q  <= cfg_data;
				REG_WINDOW_SIDE: side_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		dims.rows  = clamp_side(row_q);
		dims.cols  = clamp_side(col_q);
		dims.side  = CNT_BITS'(side_q);
		small_side = (dims.rows < dims.cols) ? dims.rows : dims.cols;
		bad = (side_q == '0) || (SIDE_CMP_BITS'(side_q) > SIDE_CMP_BITS'(small_side));
	end

	assign load_en = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (load_en && load_last) begin
					state_next = bad ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!gen_busy && !best_busy) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					state_next = ST_LOAD;
				end
			end
			default: state_next = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		scan_start  = 1'b0;
		result_load = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ch.ready = 1'b1;
				scan_start  = in_ch.valid && load_last && !bad;
			end
			ST_SCAN: ;
			ST_FINISH: begin
				result_load = !out_valid_q || out_ch.ready;
			end
			default: ;
		endcase
	end

	mssw_addr_gen u_addr_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_en    (load_en),
		.scan_start (scan_start),
		.dims       (dims),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.tag        (tag),
		.load_last  (load_last),
		.busy       (gen_busy)
	);

	mssw_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (to_store(in_ch.sample)),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	mssw_best u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (scan_start),
		.tag      (tag),
		.rd_data  (rd_data),
		.best_sum (best_sum),
		.best_row (best_row),
		.best_col (best_col),
		.busy     (best_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			out_ch.bad_window <= bad;
			out_ch.best_sum   <= bad ? '0 : best_sum;
			out_ch.top_row    <= bad ? '0 : POS_BITS'(best_row);
			out_ch.left_col   <= bad ? '0 : POS_BITS'(best_col);
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

>>> rtl/mssw_checker.sv
module mssw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [mssw_pkg::SUM_BITS-1:0] out_best_sum,
	input logic [mssw_pkg::POS_BITS-1:0]       out_top_row,
	input logic [mssw_pkg::POS_BITS-1:0]       out_left_col,
	input logic                                out_bad_window
);
	import mssw_pkg::*;

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_best_sum) && $stable(out_top_row)
			&& $stable(out_left_col) && $stable(out_bad_window))
		else $error("result changed while stalled");

	// a bad window side reports no position and no sum
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad_window |-> out_best_sum == '0 && out_top_row == '0
			&& out_left_col == '0)
		else $error("bad window result carries data");

	// a new result only appears once the load side has stopped taking items
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while loading");

endmodule

bind max_sum_square_window mssw_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_best_sum   (out_ch.best_sum),
	.out_top_row    (out_ch.top_row),
	.out_left_col   (out_ch.left_col),
	.out_bad_window (out_ch.bad_window)
);
